### design/pmp_pkg.sv
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared sizes, header constants, frame type codes, field kinds and parser
// phases of the pairing parser.
// ----------------------------------------------------------------------------
package pmp_pkg;

   // Field sizes in bytes.
   localparam int ID_BYTES     = 32;
   localparam int NAME_BYTES   = 64;
   localparam int SECRET_BYTES = 64;

   // Header contents.
   localparam logic [7:0] MAGIC_0       = 8'h41;
   localparam logic [7:0] MAGIC_1       = 8'h4C;
   localparam logic [7:0] MAGIC_2       = 8'h54;
   localparam logic [7:0] MAGIC_3       = 8'h50;
   localparam logic [7:0] FRAME_VERSION = 8'd1;

   // Frame type codes as carried in the type byte.
   localparam logic [7:0] T_REQUEST = 8'd1;
   localparam logic [7:0] T_CONFIRM = 8'd2;
   localparam logic [7:0] T_ACCEPT  = 8'd3;
   localparam logic [7:0] T_REJECT  = 8'd4;

   // Field kinds reported with each result item.
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ID     = 2'd1;
   localparam logic [1:0] KIND_NAME   = 2'd2;
   localparam logic [1:0] KIND_SECRET = 2'd3;

   // Parser phases.
   localparam logic [3:0] PH_HEADER  = 4'd0;
   localparam logic [3:0] PH_ID      = 4'd1;
   localparam logic [3:0] PH_NAMELEN = 4'd2;
   localparam logic [3:0] PH_NAME    = 4'd3;
   localparam logic [3:0] PH_CODE    = 4'd4;
   localparam logic [3:0] PH_SECLEN  = 4'd5;
   localparam logic [3:0] PH_SECRET  = 4'd6;
   localparam logic [3:0] PH_DONE    = 4'd7;

   localparam logic [8:0] BYTE_COUNT_MAX = 9'd511;

endpackage

### design/pairing_message_parser.sv
// ----------------------------------------------------------------------------
// pairing_message_parser
// Checks a pairing datagram one byte per item and emits one result per byte.
// ----------------------------------------------------------------------------
// The result item for an accepted byte is registered and appears in the cycle after it is accepted.
// Throughput: one byte per cycle while the downstream side takes each item;
// the result register frees itself in the same cycle that it takes its item.
// Reset: synchronous, active high; the parser returns to the header phase
// with all held fields cleared and no result pending.
// ----------------------------------------------------------------------------
module pairing_message_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // end_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] field_byte, [15:8] field_pos, [16] frame_valid, [19:17] frame_type,
   // [51:20] confirm_code, [59:52] name_length, [67:60] secret_length,
   // [71:68] zero
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // field_kind
   output logic        rsp_tlast    // frame_done
);

   // Frame state.
   logic [3:0]  phase_ff, phase_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  field_count_ff, field_count_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_name_size_ff, held_name_size_in;
   logic [7:0]  held_secret_size_ff, held_secret_size_in;
   logic [31:0] code_shift_ff, code_shift_in;
   logic        error_flag_ff, error_flag_in;

   // Result register.
   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff;

   logic        accept;
   logic [7:0]  rx_byte;
   logic        eof;
   logic [1:0]  kind;
   logic [7:0]  fb, pos;
   logic [8:0]  count_inc;
   logic        ok;
   logic        frame_valid;
   logic [2:0]  frame_type;
   logic [31:0] confirm_code;
   logic [7:0]  name_length, secret_length;

   // A new byte is taken whenever the result register is empty or is being
   // drained in this very cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;
   assign eof        = req_tlast;
   assign count_inc  = {1'b0, field_count_ff} + 9'd1;

   // Per-byte parse step. Each phase consumes the byte and decides where the
   // next one belongs; after an error the frame is simply run out.
   always_comb begin
      phase_in            = phase_ff;
      field_count_in      = field_count_ff;
      held_type_in        = held_type_ff;
      held_name_size_in   = held_name_size_ff;
      held_secret_size_in = held_secret_size_ff;
      code_shift_in       = code_shift_ff;
      error_flag_in       = error_flag_ff;
      kind                = pmp_pkg::KIND_NONE;
      fb                  = 8'd0;
      pos                 = 8'd0;
      if (!error_flag_ff) begin
         case (phase_ff)
            pmp_pkg::PH_HEADER: begin
               if (byte_count_ff == 9'd0) begin
                  if (rx_byte != pmp_pkg::MAGIC_0) error_flag_in = 1'b1;
               end else if (byte_count_ff == 9'd1) begin
                  if (rx_byte != pmp_pkg::MAGIC_1) error_flag_in = 1'b1;
               end else if (byte_count_ff == 9'd2) begin
                  if (rx_byte != pmp_pkg::MAGIC_2) error_flag_in = 1'b1;
               end else if (byte_count_ff == 9'd3) begin
                  if (rx_byte != pmp_pkg::MAGIC_3) error_flag_in = 1'b1;
               end else if (byte_count_ff == 9'd4) begin
                  if (rx_byte != pmp_pkg::FRAME_VERSION) error_flag_in = 1'b1;
               end else begin
                  held_type_in   = rx_byte;
                  field_count_in = 8'd0;
                  if (rx_byte >= pmp_pkg::T_REQUEST && rx_byte <= pmp_pkg::T_ACCEPT) begin
                     phase_in = pmp_pkg::PH_ID;
                  end else if (rx_byte == pmp_pkg::T_REJECT) begin
                     phase_in = pmp_pkg::PH_DONE;
                  end else begin
                     error_flag_in = 1'b1;
                  end
               end
            end
            pmp_pkg::PH_ID: begin
               kind = pmp_pkg::KIND_ID;
               pos  = field_count_ff;
               // The final id byte is always reported as zero.
               fb   = (field_count_ff == 8'(pmp_pkg::ID_BYTES - 1)) ? 8'd0 : rx_byte;
               field_count_in = count_inc[7:0];
               if (count_inc >= 9'(pmp_pkg::ID_BYTES)) begin
                  field_count_in = 8'd0;
                  phase_in = (held_type_ff == pmp_pkg::T_CONFIRM) ? pmp_pkg::PH_CODE :
                                                                     pmp_pkg::PH_NAMELEN;
               end
            end
            pmp_pkg::PH_NAMELEN: begin
               held_name_size_in = rx_byte;
               field_count_in    = 8'd0;
               if ({1'b0, rx_byte} > 9'(pmp_pkg::NAME_BYTES - 1)) begin
                  error_flag_in = 1'b1;
               end else if (rx_byte == 8'd0) begin
                  phase_in = (held_type_ff == pmp_pkg::T_ACCEPT) ? pmp_pkg::PH_SECLEN :
                                                                    pmp_pkg::PH_DONE;
               end else begin
                  phase_in = pmp_pkg::PH_NAME;
               end
            end
            pmp_pkg::PH_NAME: begin
               kind = pmp_pkg::KIND_NAME;
               pos  = field_count_ff;
               fb   = rx_byte;
               field_count_in = count_inc[7:0];
               if (count_inc >= {1'b0, held_name_size_ff}) begin
                  field_count_in = 8'd0;
                  phase_in = (held_type_ff == pmp_pkg::T_ACCEPT) ? pmp_pkg::PH_SECLEN :
                                                                    pmp_pkg::PH_DONE;
               end
            end
            pmp_pkg::PH_CODE: begin
               code_shift_in  = {code_shift_ff[23:0], rx_byte};
               field_count_in = count_inc[7:0];
               if (count_inc >= 9'd4) begin
                  field_count_in = 8'd0;
                  phase_in = pmp_pkg::PH_DONE;
               end
            end
            pmp_pkg::PH_SECLEN: begin
               held_secret_size_in = rx_byte;
               field_count_in      = 8'd0;
               if ({1'b0, rx_byte} > 9'(pmp_pkg::SECRET_BYTES - 1)) begin
                  error_flag_in = 1'b1;
               end else if (rx_byte == 8'd0) begin
                  phase_in = pmp_pkg::PH_DONE;
               end else begin
                  phase_in = pmp_pkg::PH_SECRET;
               end
            end
            pmp_pkg::PH_SECRET: begin
               kind = pmp_pkg::KIND_SECRET;
               pos  = field_count_ff;
               fb   = rx_byte;
               field_count_in = count_inc[7:0];
               if (count_inc >= {1'b0, held_secret_size_ff}) begin
                  field_count_in = 8'd0;
                  phase_in = pmp_pkg::PH_DONE;
               end
            end
            default: begin
               // Trailing bytes after a complete frame are ignored.
            end
         endcase
      end
   end

   assign byte_count_in = (byte_count_ff < pmp_pkg::BYTE_COUNT_MAX) ?
                          byte_count_ff + 9'd1 : byte_count_ff;

   // The verdict looks at the state as it stands after this byte.
   always_comb begin
      ok            = !error_flag_in && (phase_in == pmp_pkg::PH_DONE);
      frame_valid   = 1'b0;
      frame_type    = 3'd0;
      confirm_code  = 32'd0;
      name_length   = 8'd0;
      secret_length = 8'd0;
      if (eof && ok) begin
         frame_valid = 1'b1;
         frame_type  = held_type_in[2:0];
         if (held_type_in == pmp_pkg::T_CONFIRM) confirm_code = code_shift_in;
         if (held_type_in == pmp_pkg::T_REQUEST || held_type_in == pmp_pkg::T_ACCEPT)
            name_length = held_name_size_in;
         if (held_type_in == pmp_pkg::T_ACCEPT) secret_length = held_secret_size_in;
      end
      rsp_kind_in = kind;
      rsp_data_in = {4'd0, secret_length, name_length, confirm_code, frame_type,
                     frame_valid, pos, fb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= pmp_pkg::PH_HEADER;
         byte_count_ff       <= 9'd0;
         field_count_ff      <= 8'd0;
         held_type_ff        <= 8'd0;
         held_name_size_ff   <= 8'd0;
         held_secret_size_ff <= 8'd0;
         code_shift_ff       <= 32'd0;
         error_flag_ff       <= 1'b0;
      end else if (accept) begin
         if (eof) begin
            // The byte after the end of a frame starts a fresh one.
            phase_ff            <= pmp_pkg::PH_HEADER;
            byte_count_ff       <= 9'd0;
            field_count_ff      <= 8'd0;
            held_type_ff        <= 8'd0;
            held_name_size_ff   <= 8'd0;
            held_secret_size_ff <= 8'd0;
            code_shift_ff       <= 32'd0;
            error_flag_ff       <= 1'b0;
         end else begin
            phase_ff            <= phase_in;
            byte_count_ff       <= byte_count_in;
            field_count_ff      <= field_count_in;
            held_type_ff        <= held_type_in;
            held_name_size_ff   <= held_name_size_in;
            held_secret_size_ff <= held_secret_size_in;
            code_shift_ff       <= code_shift_in;
            error_flag_ff       <= error_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= eof;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
